@@ design/qda_pkg.sv @@
// Shared types, constants and codes for the quadrature detent quantizer.
package qda_pkg;

    // Field and datapath widths
    localparam int CW          = 16;               // counter bits in use
    localparam int RAW_W       = 16;               // raw_count field width
    localparam int TIME_W      = 32;               // now_ms field width
    localparam int DIV_W       = 8;                // counts_per_detent width
    localparam int MS_W        = 16;               // threshold register width
    localparam int MULT_W      = 4;                // multiplier register width
    localparam int ACC_W       = CW + 2;           // remainder plus delta
    localparam int PROD_W      = ACC_W + MULT_W + 1;
    localparam int STEPS_W     = 20;
    localparam int CNT_W       = $clog2(ACC_W);
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Saturation bounds of the result
    localparam logic signed [PROD_W-1:0] STEPS_MAX = PROD_W'((2 ** (STEPS_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] STEPS_MIN = -PROD_W'(2 ** (STEPS_W - 1));

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CPD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MED_MS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MULT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MED_MULT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_EN  = 3'd6;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_PREP,
        ST_DIV,
        ST_ACCEL,
        ST_EMIT
    } state_t;

    // Configuration register file contents
    typedef struct packed {
        logic              invert;
        logic [DIV_W-1:0]  cpd;
        logic [MS_W-1:0]   fast_ms;
        logic [MS_W-1:0]   med_ms;
        logic [MULT_W-1:0] fast_mult;
        logic [MULT_W-1:0] med_mult;
        logic              accel_en;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic prime;
        logic prep;
        logic div_step;
        logic accel;
        logic emit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic primed;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

@@ design/qda_ctrl.sv @@
// Sequencing state machine for the detent quantizer.
module qda_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  qda_pkg::status_t status,
    output qda_pkg::cmd_t    cmd
);

    qda_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qda_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qda_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.primed ? qda_pkg::ST_PREP : qda_pkg::ST_PRIME;
                end
            end
            qda_pkg::ST_PRIME: state_next = qda_pkg::ST_EMIT;
            qda_pkg::ST_PREP:  state_next = qda_pkg::ST_DIV;
            qda_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = qda_pkg::ST_ACCEL;
                end
            end
            qda_pkg::ST_ACCEL: state_next = qda_pkg::ST_EMIT;
            qda_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = qda_pkg::ST_IDLE;
                end
            end
            default: state_next = qda_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            qda_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            qda_pkg::ST_PRIME: cmd.prime    = 1'b1;
            qda_pkg::ST_PREP:  cmd.prep     = 1'b1;
            qda_pkg::ST_DIV:   cmd.div_step = 1'b1;
            qda_pkg::ST_ACCEL: cmd.accel    = 1'b1;
            qda_pkg::ST_EMIT:  cmd.emit     = status.out_free;
            default: cmd = '0;
        endcase
    end

    // A result is only loaded into a free output slot.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("emit while output slot busy");

    // A new request is only taken once the previous one has been handed on.
    a_capture_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == qda_pkg::ST_EMIT && !status.out_free) |=> !cmd.capture)
        else $error("request taken before result was delivered");

endmodule

@@ design/qda_dp.sv @@
// Datapath: delta, iterative divider, acceleration multiply and output register.
module qda_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  qda_pkg::cfg_t                       cfg,
    input  qda_pkg::cmd_t                       cmd,
    output qda_pkg::status_t                    status,
    input  logic [qda_pkg::RAW_W-1:0]           in_raw,
    input  logic [qda_pkg::TIME_W-1:0]          in_now,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qda_pkg::STEPS_W-1:0]  out_steps
);

    // Captured request
    logic [qda_pkg::RAW_W-1:0]         raw_reg;
    logic [qda_pkg::TIME_W-1:0]        now_reg;
    // Persistent state
    logic [qda_pkg::CW-1:0]            baseline_reg;
    logic signed [qda_pkg::ACC_W-1:0]  remainder_reg;
    logic [qda_pkg::TIME_W-1:0]        last_time_reg;
    logic                              primed_reg;
    // Divider
    logic [qda_pkg::ACC_W-1:0]         quot_reg;
    logic [qda_pkg::DIV_W:0]           div_rem_reg;
    logic [qda_pkg::CNT_W-1:0]         cnt_reg;
    logic                              neg_reg;
    // Result
    logic signed [qda_pkg::PROD_W-1:0] prod_reg;
    logic                              out_valid_reg;
    logic signed [qda_pkg::STEPS_W-1:0] out_steps_reg;

    logic [qda_pkg::DIV_W-1:0]         divisor;
    logic [qda_pkg::CW-1:0]            delta;
    logic signed [qda_pkg::ACC_W-1:0]  delta_ext;
    logic signed [qda_pkg::ACC_W-1:0]  delta_dir;
    logic signed [qda_pkg::ACC_W-1:0]  acc;
    logic [qda_pkg::ACC_W-1:0]         acc_mag;
    logic [qda_pkg::DIV_W:0]           trial;
    logic                              trial_ge;
    logic signed [qda_pkg::ACC_W-1:0]  detents;
    logic signed [qda_pkg::ACC_W-1:0]  rem_signed;
    logic [qda_pkg::TIME_W-1:0]        dt;
    logic                              do_accel;
    logic [qda_pkg::MULT_W-1:0]        mult_sel;
    logic signed [qda_pkg::MULT_W:0]   mult_s;
    logic signed [qda_pkg::PROD_W-1:0] prod;
    logic signed [qda_pkg::STEPS_W-1:0] sat_steps;
    logic                              out_free;

    // Divisor of zero acts as one
    assign divisor = (cfg.cpd == '0) ? qda_pkg::DIV_W'(1) : cfg.cpd;

    // Wrapped counter delta, direction and accumulation
    always_comb begin
        delta     = raw_reg[qda_pkg::CW-1:0] - baseline_reg;
        delta_ext = qda_pkg::ACC_W'($signed(delta));
        delta_dir = cfg.invert ? -delta_ext : delta_ext;
        acc       = remainder_reg + delta_dir;
        acc_mag   = acc[qda_pkg::ACC_W-1] ? qda_pkg::ACC_W'(-acc) : qda_pkg::ACC_W'(acc);
    end

    // One restoring division step
    always_comb begin
        trial    = {div_rem_reg[qda_pkg::DIV_W-1:0], quot_reg[qda_pkg::ACC_W-1]};
        trial_ge = (trial >= {1'b0, divisor});
    end

    // Signed quotient and remainder, acceleration select
    always_comb begin
        detents    = neg_reg ? -$signed(quot_reg) : $signed(quot_reg);
        rem_signed = qda_pkg::ACC_W'($signed({1'b0, div_rem_reg[qda_pkg::DIV_W-1:0]}));
        if (neg_reg) begin
            rem_signed = -rem_signed;
        end
        dt       = now_reg - last_time_reg;
        do_accel = cfg.accel_en && (detents != '0);
        if (dt <= qda_pkg::TIME_W'(cfg.fast_ms)) begin
            mult_sel = cfg.fast_mult;
        end else if (dt <= qda_pkg::TIME_W'(cfg.med_ms)) begin
            mult_sel = cfg.med_mult;
        end else begin
            mult_sel = qda_pkg::MULT_W'(1);
        end
        mult_s = do_accel ? $signed({1'b0, mult_sel}) : (qda_pkg::MULT_W + 1)'(1);
        prod   = qda_pkg::PROD_W'(detents) * qda_pkg::PROD_W'(mult_s);
    end

    // Saturate to the result range
    always_comb begin
        if (prod_reg > qda_pkg::STEPS_MAX) begin
            sat_steps = qda_pkg::STEPS_MAX[qda_pkg::STEPS_W-1:0];
        end else if (prod_reg < qda_pkg::STEPS_MIN) begin
            sat_steps = qda_pkg::STEPS_MIN[qda_pkg::STEPS_W-1:0];
        end else begin
            sat_steps = prod_reg[qda_pkg::STEPS_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // Control state: primed flag and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.prime) begin
                primed_reg <= 1'b1;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Persistent state, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg  <= '0;
            remainder_reg <= '0;
            last_time_reg <= '0;
        end else begin
            if (cmd.prime) begin
                baseline_reg  <= raw_reg[qda_pkg::CW-1:0];
                remainder_reg <= '0;
            end
            if (cmd.prep) begin
                baseline_reg <= raw_reg[qda_pkg::CW-1:0];
            end
            if (cmd.accel) begin
                remainder_reg <= rem_signed;
                if (do_accel) begin
                    last_time_reg <= now_reg;
                end
            end
        end
    end

    // Request capture, divider and result payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            raw_reg <= in_raw;
            now_reg <= in_now;
        end
        if (cmd.prep) begin
            quot_reg    <= acc_mag;
            div_rem_reg <= '0;
            cnt_reg     <= '0;
            neg_reg     <= acc[qda_pkg::ACC_W-1];
        end
        if (cmd.div_step) begin
            quot_reg    <= {quot_reg[qda_pkg::ACC_W-2:0], trial_ge};
            div_rem_reg <= trial_ge ? (trial - {1'b0, divisor}) : trial;
            cnt_reg     <= cnt_reg + 1'b1;
        end
        if (cmd.prime) begin
            prod_reg <= '0;
        end
        if (cmd.accel) begin
            prod_reg <= prod;
        end
        if (cmd.emit) begin
            out_steps_reg <= sat_steps;
        end
    end

    assign status.primed   = primed_reg;
    assign status.div_last = (cnt_reg == qda_pkg::CNT_W'(qda_pkg::ACC_W - 1));
    assign status.out_free = out_free;
    assign out_valid       = out_valid_reg;
    assign out_steps       = out_steps_reg;

    // The partial remainder stays below the divisor after every step.
    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (div_rem_reg < {1'b0, divisor}))
        else $error("divider partial remainder out of range");

    // The baseline capture marks the block primed.
    a_prime_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.prime |=> primed_reg)
        else $error("primed flag not set after baseline capture");

endmodule

@@ design/quadrature_detent_accel.sv @@
// Top level: rotary encoder detent quantizer with time-based acceleration.
// Sequence: a primed request passes through a setup state, the bit-serial 18-step
// divider, a multiply state and an output load that waits for a free output slot;
// the first request after reset only takes the baseline and gives a zero result.
// A new request is taken only once the previous result has been loaded for output.
// Reset: synchronous active-low aresetn restores register defaults and unprimes.
module quadrature_detent_accel (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: raw_count[15:0], now_ms[47:16]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [qda_pkg::IN_TDATA_W-1:0]     s_tdata,
    // tdata: steps[19:0] (signed), zero fill [23:20]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [qda_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Register write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qda_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qda_pkg::CFG_DATA_W-1:0]     cfg_data
);

    qda_pkg::cfg_t    cfg_reg;
    qda_pkg::cmd_t    cmd;
    qda_pkg::status_t status;
    logic signed [qda_pkg::STEPS_W-1:0] steps;

    assign cfg_ready = 1'b1;

    // Configuration register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.invert    <= 1'b0;
            cfg_reg.cpd       <= qda_pkg::DIV_W'(4);
            cfg_reg.fast_ms   <= qda_pkg::MS_W'(30);
            cfg_reg.med_ms    <= qda_pkg::MS_W'(80);
            cfg_reg.fast_mult <= qda_pkg::MULT_W'(4);
            cfg_reg.med_mult  <= qda_pkg::MULT_W'(2);
            cfg_reg.accel_en  <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                qda_pkg::REG_INVERT:    cfg_reg.invert    <= cfg_data[0];
                qda_pkg::REG_CPD:       cfg_reg.cpd       <= cfg_data[qda_pkg::DIV_W-1:0];
                qda_pkg::REG_FAST_MS:   cfg_reg.fast_ms   <= cfg_data[qda_pkg::MS_W-1:0];
                qda_pkg::REG_MED_MS:    cfg_reg.med_ms    <= cfg_data[qda_pkg::MS_W-1:0];
                qda_pkg::REG_FAST_MULT: cfg_reg.fast_mult <= cfg_data[qda_pkg::MULT_W-1:0];
                qda_pkg::REG_MED_MULT:  cfg_reg.med_mult  <= cfg_data[qda_pkg::MULT_W-1:0];
                qda_pkg::REG_ACCEL_EN:  cfg_reg.accel_en  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    qda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    qda_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .in_raw    (s_tdata[qda_pkg::RAW_W-1:0]),
        .in_now    (s_tdata[qda_pkg::RAW_W +: qda_pkg::TIME_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_steps (steps)
    );

    // Pack the result with zero fill up to a whole byte
    assign m_tdata = {{(qda_pkg::OUT_TDATA_W - qda_pkg::STEPS_W){1'b0}}, steps};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the quadrature detent quantizer with acceleration.
`timescale 1ns / 1ps

module tb;

    localparam int          HOLD_CYCLES    = 300;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          TAIL_CYCLES    = 40;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_REQUESTS = 235;
    localparam logic [qda_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Detent predictor and store of expected step counts.
    class detent_scoreboard;
        logic                        invert;
        logic [qda_pkg::DIV_W-1:0]   cpd;
        logic [qda_pkg::MS_W-1:0]    fast_ms;
        logic [qda_pkg::MS_W-1:0]    med_ms;
        logic [qda_pkg::MULT_W-1:0]  fast_mult;
        logic [qda_pkg::MULT_W-1:0]  med_mult;
        logic                        accel_en;
        logic                        primed;
        logic [qda_pkg::CW-1:0]      baseline;
        int                          leftover;
        logic [qda_pkg::TIME_W-1:0]  last_step_time;
        logic [qda_pkg::STEPS_W-1:0] expected_steps[$];
        int                          errors;

        function new();
            invert         = 1'b0;
            cpd            = 8'd4;
            fast_ms        = 16'd30;
            med_ms         = 16'd80;
            fast_mult      = 4'd4;
            med_mult       = 4'd2;
            accel_en       = 1'b1;
            primed         = 1'b0;
            baseline       = '0;
            leftover       = 0;
            last_step_time = '0;
            errors         = 0;
        endfunction

        function void note_register(logic [qda_pkg::CFG_IDX_W-1:0] idx,
                                    logic [qda_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                qda_pkg::REG_INVERT:    invert    = data[0];
                qda_pkg::REG_CPD:       cpd       = data[qda_pkg::DIV_W-1:0];
                qda_pkg::REG_FAST_MS:   fast_ms   = data[qda_pkg::MS_W-1:0];
                qda_pkg::REG_MED_MS:    med_ms    = data[qda_pkg::MS_W-1:0];
                qda_pkg::REG_FAST_MULT: fast_mult = data[qda_pkg::MULT_W-1:0];
                qda_pkg::REG_MED_MULT:  med_mult  = data[qda_pkg::MULT_W-1:0];
                qda_pkg::REG_ACCEL_EN:  accel_en  = data[0];
                default: ;
            endcase
        endfunction

        // Work out the steps that one accepted poll must produce.
        function void note_request(logic [qda_pkg::RAW_W-1:0] raw,
                                   logic [qda_pkg::TIME_W-1:0] now);
            logic [qda_pkg::CW-1:0]     wrapped;
            logic [qda_pkg::TIME_W-1:0] gap;
            int                         delta;
            int                         divisor;
            int                         acc;
            int                         detents;
            int                         mult;
            int                         result;
            // The first poll only takes the baseline.
            if (!primed) begin
                baseline = raw[qda_pkg::CW-1:0];
                leftover = 0;
                primed   = 1'b1;
                expected_steps.push_back('0);
                return;
            end
            wrapped  = raw[qda_pkg::CW-1:0] - baseline;
            delta    = $signed(wrapped);
            baseline = raw[qda_pkg::CW-1:0];
            if (invert)
                delta = -delta;
            divisor  = (cpd == 0) ? 1 : int'(cpd);
            acc      = leftover + delta;
            detents  = acc / divisor;
            leftover = acc - detents * divisor;
            result   = detents;
            // Speed-based multiplier, keyed on the gap since the last moving poll.
            if (accel_en && detents != 0) begin
                gap            = now - last_step_time;
                last_step_time = now;
                if (gap <= qda_pkg::TIME_W'(fast_ms))
                    mult = int'(fast_mult);
                else if (gap <= qda_pkg::TIME_W'(med_ms))
                    mult = int'(med_mult);
                else
                    mult = 1;
                result = detents * mult;
            end
            if (result > int'(qda_pkg::STEPS_MAX))
                result = int'(qda_pkg::STEPS_MAX);
            if (result < int'(qda_pkg::STEPS_MIN))
                result = int'(qda_pkg::STEPS_MIN);
            expected_steps.push_back(result[qda_pkg::STEPS_W-1:0]);
        endfunction

        function void check_result(logic [qda_pkg::STEPS_W-1:0] steps);
            logic [qda_pkg::STEPS_W-1:0] want;
            if (expected_steps.size() == 0) begin
                $error("steps: result with no request waiting, actual %0d", $signed(steps));
                errors++;
                return;
            end
            want = expected_steps.pop_front();
            if (steps !== want) begin
                $error("steps: expected %0d, actual %0d", $signed(want), $signed(steps));
                errors++;
            end
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [qda_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [qda_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [qda_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [qda_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    detent_scoreboard sb;
    int               send_idle_pct = 0;
    int               rcv_stall_pct = 0;
    int               hold_ticket   = 0;
    int               hold_seen;
    int               hold_left;
    int               quiet_cycles;
    logic [qda_pkg::RAW_W-1:0]  enc_raw  = '0;
    logic [qda_pkg::TIME_W-1:0] enc_time = '0;

    quadrature_detent_accel u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[qda_pkg::STEPS_W-1:0]);
            if (hold_seen != hold_ticket) begin
                hold_seen <= hold_ticket;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                     (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one poll; valid stays high afterward unless an idle gap follows.
    task automatic send_request(input logic [qda_pkg::RAW_W-1:0] raw,
                                input logic [qda_pkg::TIME_W-1:0] now);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, raw};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_request(raw, now);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // One register write; the caller lowers cfg_valid after its last write.
    task automatic cfg_write(input logic [qda_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qda_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.note_register(idx, data);
    endtask

    task automatic apply_settings(input logic inv, input logic [7:0] cpd,
                                  input logic [15:0] fast, input logic [15:0] med,
                                  input logic [3:0] fmult, input logic [3:0] mmult,
                                  input logic accel);
        cfg_write(qda_pkg::REG_INVERT,    qda_pkg::CFG_DATA_W'(inv));
        cfg_write(qda_pkg::REG_CPD,       qda_pkg::CFG_DATA_W'(cpd));
        cfg_write(qda_pkg::REG_FAST_MS,   fast);
        cfg_write(qda_pkg::REG_MED_MS,    med);
        cfg_write(qda_pkg::REG_FAST_MULT, qda_pkg::CFG_DATA_W'(fmult));
        cfg_write(qda_pkg::REG_MED_MULT,  qda_pkg::CFG_DATA_W'(mmult));
        cfg_write(qda_pkg::REG_ACCEL_EN,  qda_pkg::CFG_DATA_W'(accel));
        cfg_valid <= 1'b0;
    endtask

    // Mostly a knob being turned with realistic gaps; some jumps and time wraps.
    task automatic send_random_poll();
        int pick;
        int span;
        pick = $urandom_range(99);
        if (pick < 72) begin
            span     = (pick < 60) ? 12 : 400;
            enc_raw  = enc_raw + qda_pkg::RAW_W'($urandom_range(0, 2 * span))
                       - qda_pkg::RAW_W'(span);
            enc_time = enc_time + qda_pkg::TIME_W'($urandom_range(0, 120));
        end else if (pick < 86) begin
            enc_raw  = qda_pkg::RAW_W'($urandom);
            enc_time = enc_time + qda_pkg::TIME_W'($urandom_range(0, 2000));
        end else if (pick < 95) begin
            enc_raw  = enc_raw + qda_pkg::RAW_W'($urandom_range(0, 16)) - qda_pkg::RAW_W'(8);
            enc_time = $urandom;
        end else begin
            enc_raw  = enc_raw + qda_pkg::RAW_W'($urandom_range(0, 16));
            enc_time = 32'hFFFF_FFFF - qda_pkg::TIME_W'($urandom_range(0, 60));
        end
        send_request(enc_raw, enc_time);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: priming poll, counter wrap, both extreme differences.
        send_request(16'hFFFF, 32'hFFFF_FFFF);
        send_request(16'h0003, 32'd5);
        send_request(16'h0003, 32'd6);
        send_request(16'h0001, 32'd40);
        send_request(16'hFFFF, 32'd100);
        send_request(16'h7FFE, 32'd150);
        send_request(16'hFFFE, 32'd160);
        send_request(16'hFFFE, 32'h7FFF_FFFF);
        drain_requests();

        // An unused register index must leave every setting alone.
        cfg_write(REG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_request(16'h0002, 32'd170);
        drain_requests();

        // Inverted, divisor one, zero thresholds, largest multipliers.
        apply_settings(1'b1, 8'd1, 16'd0, 16'd0, 4'd15, 4'd15, 1'b1);
        send_request(16'h8001, 32'd170);
        send_request(16'h0001, 32'd170);
        send_request(16'h0000, 32'd171);
        drain_requests();

        // Zero divisor and zero multipliers, widest thresholds, time wrap.
        apply_settings(1'b0, 8'd0, 16'hFFFF, 16'hFFFF, 4'd0, 4'd0, 1'b1);
        send_request(16'h0005, 32'hFFFF_FFF0);
        send_request(16'h0009, 32'd5);
        send_request(16'h0009, 32'hFFFF_0000);
        drain_requests();

        // Acceleration off, largest divisor.
        apply_settings(1'b0, 8'd255, 16'd30, 16'd80, 4'd4, 4'd2, 1'b0);
        send_request(16'h0108, 32'd10);
        send_request(16'hFF00, 32'd11);
        send_request(16'h0000, 32'd12);
        drain_requests();
        enc_raw  = 16'h0000;
        enc_time = 32'd12;

        // Random phases, each with its own settings, cycling through four idle patterns.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: apply_settings(1'b0, 8'd4, 16'd30, 16'd80, 4'd4, 4'd2, 1'b1);
                1: apply_settings(1'b1, 8'd1, 16'd0, 16'd0, 4'd15, 4'd15, 1'b1);
                2: apply_settings(1'b0, 8'd255, 16'hFFFF, 16'hFFFF, 4'd1, 4'd1, 1'b1);
                3: apply_settings(1'b1, 8'd0, 16'd20, 16'd60, 4'd0, 4'd0, 1'b1);
                4: apply_settings(1'b0, 8'd3, 16'd10, 16'd40, 4'd15, 4'd7, 1'b0);
                default:
                    apply_settings(1'($urandom_range(1)), 8'($urandom_range(1, 12)),
                                   16'($urandom_range(0, 100)), 16'($urandom_range(0, 200)),
                                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                   1'($urandom_range(1)));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; rcv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rcv_stall_pct = 86; end
                default: begin send_idle_pct = 30; rcv_stall_pct = 30; end
            endcase
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Back-pressure: a long output hold-off, then a full pause.
                if (ph % 4 == 0 && n == 60)
                    hold_ticket <= hold_ticket + 1;
                if (ph % 4 == 0 && n == 150)
                    drain_requests();
                send_random_poll();
            end
            drain_requests();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
